FILE: rtl/core/lhr_pkg.sv
// constants, codes and helper functions for the latency histogram recorder
`timescale 1ns / 1ps

package lhr_pkg;

    localparam int METHOD_COUNT_DEF = 10;
    localparam int CLASS_COUNT      = 6;
    localparam int BUCKET_COUNT     = 11;
    localparam int SLOT_COUNT       = BUCKET_COUNT + 1;

    localparam int CMD_W    = 3;
    localparam int METHOD_W = 4;
    localparam int STATUS_W = 10;
    localparam int CLASS_W  = 3;
    localparam int SLOT_W   = 4;
    localparam int VALUE_W  = 64;

    localparam logic [CLASS_W-1:0] ERROR_CLASS = CLASS_W'(5);

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD      = 3'd0,
        CMD_READ_BUCKET = 3'd1,
        CMD_READ_COUNT  = 3'd2,
        CMD_READ_SUM    = 3'd3,
        CMD_READ_ERRORS = 3'd4,
        CMD_CLEAR       = 3'd5
    } cmd_t;

    // upper bound of each latency bucket in ns
    function automatic logic [VALUE_W-1:0] bound_of(input logic [SLOT_W-1:0] slot);
        logic [VALUE_W-1:0] b;
        case (slot)
            4'd0:    b = 64'd5000000;
            4'd1:    b = 64'd10000000;
            4'd2:    b = 64'd25000000;
            4'd3:    b = 64'd50000000;
            4'd4:    b = 64'd100000000;
            4'd5:    b = 64'd250000000;
            4'd6:    b = 64'd500000000;
            4'd7:    b = 64'd1000000000;
            4'd8:    b = 64'd2500000000;
            4'd9:    b = 64'd5000000000;
            4'd10:   b = 64'd10000000000;
            default: b = '1;
        endcase
        return b;
    endfunction

    // hundreds digit of the status when it is 1 to 5, else 0
    function automatic logic [CLASS_W-1:0] class_of(input logic [STATUS_W-1:0] status);
        logic [CLASS_W-1:0] c;
        if (status < 10'd100) begin
            c = CLASS_W'(0);
        end else if (status < 10'd200) begin
            c = CLASS_W'(1);
        end else if (status < 10'd300) begin
            c = CLASS_W'(2);
        end else if (status < 10'd400) begin
            c = CLASS_W'(3);
        end else if (status < 10'd500) begin
            c = CLASS_W'(4);
        end else if (status < 10'd600) begin
            c = CLASS_W'(5);
        end else begin
            c = CLASS_W'(0);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/latency_histogram_recorder.sv
// latency histogram recorder: sequencer around bucket, entry and error memories
`timescale 1ns / 1ps

// Keeps one 12-slot latency histogram, a count and a duration sum for every
// (method, status class) pair, and a 5xx counter per method, all in single-port
// memories with registered read data. One item is worked on at a time; s_ready
// is high only while the sequencer is idle, and a finished result waits in the
// output register so the next item can be taken meanwhile. A record compares
// the bucket bounds one per cycle before the read-modify-write, and a
// cumulative read does one bucket memory read per summed slot. A clear
// command, and reset, sweep every memory address once, during which no item
// is taken.
module latency_histogram_recorder #(
    parameter int METHOD_COUNT = lhr_pkg::METHOD_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lhr_pkg::CMD_W-1:0]      s_cmd,
    input  logic [lhr_pkg::METHOD_W-1:0]   s_method,
    input  logic [lhr_pkg::STATUS_W-1:0]   s_status,
    input  logic [lhr_pkg::CLASS_W-1:0]    s_query_class,
    input  logic [lhr_pkg::SLOT_W-1:0]     s_bucket_index,
    input  logic [lhr_pkg::VALUE_W-1:0]    s_duration_ns,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lhr_pkg::VALUE_W-1:0]    m_read_value,
    output logic [lhr_pkg::SLOT_W-1:0]     m_slot_taken,
    output logic [lhr_pkg::CLASS_W-1:0]    m_class_taken,
    output logic                           m_rejected
);

    import lhr_pkg::*;

    localparam int ENTRY_COUNT = METHOD_COUNT * CLASS_COUNT;
    localparam int BKT_DEPTH   = ENTRY_COUNT * SLOT_COUNT;
    localparam int MTH_W       = (METHOD_COUNT > 1) ? $clog2(METHOD_COUNT) : 1;
    localparam int ENTRY_W     = $clog2(ENTRY_COUNT);
    localparam int BKT_AW      = $clog2(BKT_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MODIFY,
        ST_CUM,
        ST_CUM_LAST,
        ST_FETCH,
        ST_PICK
    } state_t;

    state_t               state_reg;
    logic                 done_reg;
    logic                 clr_for_cmd_reg;
    logic [BKT_AW-1:0]    clr_addr_reg;
    logic                 enabled_reg;

    cmd_t                 cmd_reg;
    logic [MTH_W-1:0]     method_reg;
    logic [ENTRY_W-1:0]   entry_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [SLOT_W-1:0]    last_reg;
    logic [VALUE_W-1:0]   dur_reg;
    logic                 pend_reg;

    logic [VALUE_W-1:0]   res_value_reg;
    logic [SLOT_W-1:0]    res_slot_reg;
    logic [CLASS_W-1:0]   res_class_reg;
    logic                 res_rej_reg;

    logic                 m_valid_reg;
    logic [VALUE_W-1:0]   m_value_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic [CLASS_W-1:0]   m_class_reg;
    logic                 m_rej_reg;

    logic [VALUE_W-1:0]   bkt_mem [0:BKT_DEPTH-1];
    logic [VALUE_W-1:0]   cnt_mem [0:ENTRY_COUNT-1];
    logic [VALUE_W-1:0]   sum_mem [0:ENTRY_COUNT-1];
    logic [VALUE_W-1:0]   err_mem [0:METHOD_COUNT-1];
    logic [VALUE_W-1:0]   bkt_rdata_reg;
    logic [VALUE_W-1:0]   cnt_rdata_reg;
    logic [VALUE_W-1:0]   sum_rdata_reg;
    logic [VALUE_W-1:0]   err_rdata_reg;

    logic                 clearing;
    logic                 modify_en;
    logic                 out_free;
    logic                 in_accept;
    logic [BKT_AW-1:0]    bkt_addr;
    logic [ENTRY_W-1:0]   ent_addr;
    logic [MTH_W-1:0]     err_addr;
    logic                 bkt_we;
    logic                 ent_we;
    logic                 err_we;
    logic [VALUE_W-1:0]   bkt_wdata;
    logic [VALUE_W-1:0]   cnt_wdata;
    logic [VALUE_W-1:0]   sum_wdata;
    logic [VALUE_W-1:0]   err_wdata;
    logic                 slot_hit;

    cmd_t                 in_cmd;
    logic [MTH_W-1:0]     in_method;
    logic [CLASS_W-1:0]   in_class;
    logic [CLASS_W-1:0]   sel_class;
    logic [ENTRY_W-1:0]   in_entry;
    logic                 class_bad;
    logic                 bucket_bad;

    assign s_ready       = (state_reg == ST_IDLE);
    assign in_accept     = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_value_reg;
    assign m_slot_taken  = m_slot_reg;
    assign m_class_taken = m_class_reg;
    assign m_rejected    = m_rej_reg;

    // input decode
    always_comb begin
        in_cmd     = cmd_t'(s_cmd);
        in_method  = (int'(s_method) < METHOD_COUNT) ? MTH_W'(s_method) : '0;
        in_class   = class_of(s_status);
        sel_class  = (in_cmd == CMD_RECORD) ? in_class : s_query_class;
        in_entry   = ENTRY_W'(int'(in_method) * CLASS_COUNT + int'(sel_class));
        class_bad  = (int'(s_query_class) >= CLASS_COUNT);
        bucket_bad = (int'(s_bucket_index) >= BUCKET_COUNT);
    end

    // memory addressing and write-back
    always_comb begin
        clearing  = (state_reg == ST_CLEAR);
        modify_en = (state_reg == ST_MODIFY) && enabled_reg;
        slot_hit  = (int'(idx_reg) == BUCKET_COUNT) || (dur_reg <= bound_of(idx_reg));
        if (clearing) begin
            bkt_addr = clr_addr_reg;
            ent_addr = ENTRY_W'(clr_addr_reg);
            err_addr = MTH_W'(clr_addr_reg);
        end else begin
            bkt_addr = BKT_AW'(int'(entry_reg) * SLOT_COUNT + int'(idx_reg));
            ent_addr = entry_reg;
            err_addr = method_reg;
        end
        bkt_we    = clearing || modify_en;
        ent_we    = (clearing && (int'(clr_addr_reg) < ENTRY_COUNT)) || modify_en;
        err_we    = (clearing && (int'(clr_addr_reg) < METHOD_COUNT))
                    || (modify_en && (res_class_reg == ERROR_CLASS));
        bkt_wdata = clearing ? '0 : bkt_rdata_reg + VALUE_W'(1);
        cnt_wdata = clearing ? '0 : cnt_rdata_reg + VALUE_W'(1);
        sum_wdata = clearing ? '0 : sum_rdata_reg + dur_reg;
        err_wdata = clearing ? '0 : err_rdata_reg + VALUE_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (bkt_we) begin
            bkt_mem[bkt_addr] <= bkt_wdata;
        end
        bkt_rdata_reg <= bkt_mem[bkt_addr];
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            cnt_mem[ent_addr] <= cnt_wdata;
            sum_mem[ent_addr] <= sum_wdata;
        end
        cnt_rdata_reg <= cnt_mem[ent_addr];
        sum_rdata_reg <= sum_mem[ent_addr];
    end

    always_ff @(posedge aclk) begin
        if (err_we) begin
            err_mem[err_addr] <= err_wdata;
        end
        err_rdata_reg <= err_mem[err_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            enabled_reg <= cfg_wr_data;
        end
    end

    // sequencer and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            clr_for_cmd_reg <= 1'b0;
            done_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            pend_reg        <= 1'b0;
        end else begin
            if (done_reg && out_free) begin
                m_valid_reg <= 1'b1;
                m_value_reg <= res_value_reg;
                m_slot_reg  <= res_slot_reg;
                m_class_reg <= res_class_reg;
                m_rej_reg   <= res_rej_reg;
                done_reg    <= 1'b0;
                state_reg   <= ST_IDLE;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (int'(clr_addr_reg) == BKT_DEPTH - 1) begin
                        clr_addr_reg <= '0;
                        if (clr_for_cmd_reg) begin
                            done_reg <= 1'b1;
                            state_reg <= ST_PICK;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                        clr_for_cmd_reg <= 1'b0;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + BKT_AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        cmd_reg       <= in_cmd;
                        method_reg    <= in_method;
                        entry_reg     <= in_entry;
                        dur_reg       <= s_duration_ns;
                        last_reg      <= s_bucket_index;
                        idx_reg       <= '0;
                        pend_reg      <= 1'b0;
                        res_value_reg <= '0;
                        res_slot_reg  <= '0;
                        res_class_reg <= (in_cmd == CMD_RECORD) ? in_class : '0;
                        res_rej_reg   <= ((in_cmd == CMD_READ_BUCKET) && (class_bad || bucket_bad))
                                         || (((in_cmd == CMD_READ_COUNT)
                                              || (in_cmd == CMD_READ_SUM)) && class_bad);
                        case (in_cmd)
                            CMD_RECORD: begin
                                state_reg     <= ST_SCAN;
                            end
                            CMD_READ_BUCKET: begin
                                if (class_bad || bucket_bad) begin
                                    done_reg    <= 1'b1;
                                    state_reg   <= ST_PICK;
                                end else begin
                                    state_reg <= ST_CUM;
                                end
                            end
                            CMD_READ_COUNT, CMD_READ_SUM: begin
                                if (class_bad) begin
                                    done_reg    <= 1'b1;
                                    state_reg   <= ST_PICK;
                                end else begin
                                    state_reg <= ST_FETCH;
                                end
                            end
                            CMD_READ_ERRORS: begin
                                state_reg <= ST_FETCH;
                            end
                            CMD_CLEAR: begin
                                clr_for_cmd_reg <= 1'b1;
                                state_reg       <= ST_CLEAR;
                            end
                            default: begin
                                done_reg  <= 1'b1;
                                state_reg <= ST_PICK;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (slot_hit) begin
                        res_slot_reg <= idx_reg;
                        state_reg    <= ST_MODIFY;
                    end else begin
                        idx_reg <= idx_reg + SLOT_W'(1);
                    end
                end
                ST_MODIFY: begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_PICK;
                end
                ST_CUM: begin
                    if (pend_reg) begin
                        res_value_reg <= res_value_reg + bkt_rdata_reg;
                    end
                    pend_reg <= 1'b1;
                    if (idx_reg == last_reg) begin
                        state_reg <= ST_CUM_LAST;
                    end else begin
                        idx_reg <= idx_reg + SLOT_W'(1);
                    end
                end
                ST_CUM_LAST: begin
                    res_value_reg <= res_value_reg + bkt_rdata_reg;
                    done_reg      <= 1'b1;
                    state_reg     <= ST_PICK;
                end
                ST_FETCH: begin
                    state_reg <= ST_PICK;
                end
                ST_PICK: begin
                    // waits here for the output register while done_reg is set
                    if (!done_reg) begin
                        case (cmd_reg)
                            CMD_READ_COUNT:  res_value_reg <= cnt_rdata_reg;
                            CMD_READ_SUM:    res_value_reg <= sum_rdata_reg;
                            CMD_READ_ERRORS: res_value_reg <= err_rdata_reg;
                            default:         res_value_reg <= '0;
                        endcase
                        done_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_result_from_pick : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(done_reg))
        else $error("result appeared without a finished item");

    a_accept_starts_work : assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg != ST_IDLE) || done_reg)
        else $error("accepted item did not start");

    a_slot_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MODIFY) |-> (int'(idx_reg) <= BUCKET_COUNT))
        else $error("record slot out of range");

    a_rejected_is_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_rej_reg) |-> (m_value_reg == '0) && (m_slot_reg == '0))
        else $error("rejected read carries data");

    a_no_write_when_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !bkt_we && !ent_we && !err_we)
        else $error("memory write while idle");
`endif

endmodule

FILE: tb/histogram_checker.sv
// checker that predicts and compares every result of the latency histogram recorder
`timescale 1ns / 1ps

module histogram_checker #(
    parameter int METHOD_COUNT = lhr_pkg::METHOD_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,

    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [lhr_pkg::CMD_W-1:0]      s_cmd,
    input  logic [lhr_pkg::METHOD_W-1:0]   s_method,
    input  logic [lhr_pkg::STATUS_W-1:0]   s_status,
    input  logic [lhr_pkg::CLASS_W-1:0]    s_query_class,
    input  logic [lhr_pkg::SLOT_W-1:0]     s_bucket_index,
    input  logic [lhr_pkg::VALUE_W-1:0]    s_duration_ns,

    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [lhr_pkg::VALUE_W-1:0]    m_read_value,
    input  logic [lhr_pkg::SLOT_W-1:0]     m_slot_taken,
    input  logic [lhr_pkg::CLASS_W-1:0]    m_class_taken,
    input  logic                           m_rejected,

    output int                             mismatch_count,
    output int                             results_pending
);

    import lhr_pkg::*;

    localparam int ENTRY_TOTAL = METHOD_COUNT * CLASS_COUNT;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]  slot;
        logic [CLASS_W-1:0] cls;
        logic               rejected;
    } tally_result_t;

    logic [VALUE_W-1:0] slot_tally     [ENTRY_TOTAL*SLOT_COUNT];
    logic [VALUE_W-1:0] entry_tally    [ENTRY_TOTAL];
    logic [VALUE_W-1:0] duration_total [ENTRY_TOTAL];
    logic [VALUE_W-1:0] error_tally    [METHOD_COUNT];
    logic [VALUE_W-1:0] bucket_limit   [BUCKET_COUNT];
    logic               metrics_on;
    tally_result_t      awaited_results [$];
    tally_result_t      oldest;

    initial begin
        bucket_limit[0]  = 64'd5000000;
        bucket_limit[1]  = 64'd10000000;
        bucket_limit[2]  = 64'd25000000;
        bucket_limit[3]  = 64'd50000000;
        bucket_limit[4]  = 64'd100000000;
        bucket_limit[5]  = 64'd250000000;
        bucket_limit[6]  = 64'd500000000;
        bucket_limit[7]  = 64'd1000000000;
        bucket_limit[8]  = 64'd2500000000;
        bucket_limit[9]  = 64'd5000000000;
        bucket_limit[10] = 64'd10000000000;
    end

    function automatic void wipe_tallies();
        foreach (slot_tally[i]) slot_tally[i] = '0;
        foreach (entry_tally[i]) begin
            entry_tally[i]    = '0;
            duration_total[i] = '0;
        end
        foreach (error_tally[i]) error_tally[i] = '0;
    endfunction

    function automatic tally_result_t predict_result(
        input logic [CMD_W-1:0]    cmd,
        input logic [METHOD_W-1:0] method,
        input logic [STATUS_W-1:0] status,
        input logic [CLASS_W-1:0]  qclass,
        input logic [SLOT_W-1:0]   last_bucket,
        input logic [VALUE_W-1:0]  duration
    );
        tally_result_t r;
        int m;
        int e;
        int cls;
        int slot;
        int hundreds;
        int i;
        r = '0;
        m = (int'(method) < METHOD_COUNT) ? int'(method) : 0;
        case (cmd)
            CMD_RECORD: begin
                hundreds = int'(status) / 100;
                cls = (hundreds >= 1 && hundreds <= 5) ? hundreds : 0;
                slot = BUCKET_COUNT;
                for (i = BUCKET_COUNT - 1; i >= 0; i--) begin
                    if (duration <= bucket_limit[i]) slot = i;
                end
                r.slot = SLOT_W'(slot);
                r.cls  = CLASS_W'(cls);
                if (metrics_on) begin
                    e = m * CLASS_COUNT + cls;
                    slot_tally[e*SLOT_COUNT + slot] += 64'd1;
                    entry_tally[e]    += 64'd1;
                    duration_total[e] += duration;
                    if (cls == int'(ERROR_CLASS)) error_tally[m] += 64'd1;
                end
            end
            CMD_READ_BUCKET: begin
                if (int'(qclass) >= CLASS_COUNT || int'(last_bucket) >= BUCKET_COUNT) begin
                    r.rejected = 1'b1;
                end else begin
                    e = m * CLASS_COUNT + int'(qclass);
                    for (i = 0; i <= int'(last_bucket); i++) begin
                        r.value += slot_tally[e*SLOT_COUNT + i];
                    end
                end
            end
            CMD_READ_COUNT, CMD_READ_SUM: begin
                if (int'(qclass) >= CLASS_COUNT) begin
                    r.rejected = 1'b1;
                end else begin
                    e = m * CLASS_COUNT + int'(qclass);
                    r.value = (cmd == CMD_READ_COUNT) ? entry_tally[e] : duration_total[e];
                end
            end
            CMD_READ_ERRORS: begin
                r.value = error_tally[m];
            end
            CMD_CLEAR: begin
                wipe_tallies();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("histogram mismatch on %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            wipe_tallies();
            metrics_on = 1'b1;
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch("item with nothing awaited", '0, m_read_value);
                end else begin
                    oldest = awaited_results.pop_front();
                    if (m_read_value !== oldest.value)
                        flag_mismatch("read_value", oldest.value, m_read_value);
                    if (m_slot_taken !== oldest.slot)
                        flag_mismatch("slot_taken", 64'(oldest.slot), 64'(m_slot_taken));
                    if (m_class_taken !== oldest.cls)
                        flag_mismatch("class_taken", 64'(oldest.cls), 64'(m_class_taken));
                    if (m_rejected !== oldest.rejected)
                        flag_mismatch("rejected", 64'(oldest.rejected), 64'(m_rejected));
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(predict_result(s_cmd, s_method, s_status,
                                                         s_query_class, s_bucket_index,
                                                         s_duration_ns));
            end
            if (cfg_wr_en) metrics_on = cfg_wr_data;
        end
        results_pending <= awaited_results.size();
    end

endmodule

FILE: tb/testbench.sv
// top of the latency histogram recorder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

    import lhr_pkg::*;

    localparam logic [CMD_W-1:0]   CMD_SPARE_LOW  = 3'd6;
    localparam logic [CMD_W-1:0]   CMD_SPARE_HIGH = 3'd7;
    localparam logic [VALUE_W-1:0] MAX_NS         = '1;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 250;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                cfg_wr_en      = 1'b0;
    logic                cfg_wr_data    = 1'b0;
    logic                s_valid        = 1'b0;
    logic [CMD_W-1:0]    s_cmd          = '0;
    logic [METHOD_W-1:0] s_method       = '0;
    logic [STATUS_W-1:0] s_status       = '0;
    logic [CLASS_W-1:0]  s_query_class  = '0;
    logic [SLOT_W-1:0]   s_bucket_index = '0;
    logic [VALUE_W-1:0]  s_duration_ns  = '0;
    logic                m_ready        = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic [VALUE_W-1:0]  m_read_value;
    logic [SLOT_W-1:0]   m_slot_taken;
    logic [CLASS_W-1:0]  m_class_taken;
    logic                m_rejected;

    int   mismatch_count;
    int   results_pending;
    int   cycle_count = 0;
    logic steady      = 1'b0;
    logic hold_phase  = 1'b0;
    logic held_once   = 1'b0;

    logic [VALUE_W-1:0] limit_ns [BUCKET_COUNT];

    latency_histogram_recorder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_method       (s_method),
        .s_status       (s_status),
        .s_query_class  (s_query_class),
        .s_bucket_index (s_bucket_index),
        .s_duration_ns  (s_duration_ns),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_value   (m_read_value),
        .m_slot_taken   (m_slot_taken),
        .m_class_taken  (m_class_taken),
        .m_rejected     (m_rejected)
    );

    histogram_checker tally_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_method        (s_method),
        .s_status        (s_status),
        .s_query_class   (s_query_class),
        .s_bucket_index  (s_bucket_index),
        .s_duration_ns   (s_duration_ns),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_value    (m_read_value),
        .m_slot_taken    (m_slot_taken),
        .m_class_taken   (m_class_taken),
        .m_rejected      (m_rejected),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side, with one long hold-off while the sender keeps going
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_phase && !held_once) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                held_once = 1'b1;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    task automatic offer_request(
        input logic [CMD_W-1:0]    cmd,
        input logic [METHOD_W-1:0] method,
        input logic [STATUS_W-1:0] status,
        input logic [CLASS_W-1:0]  qclass,
        input logic [SLOT_W-1:0]   last_bucket,
        input logic [VALUE_W-1:0]  duration
    );
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_method       <= method;
        s_status       <= status;
        s_query_class  <= qclass;
        s_bucket_index <= last_bucket;
        s_duration_ns  <= duration;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!steady && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic await_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    task automatic set_metrics(input logic enable_bit);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= enable_bit;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int pick_class();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 2;
        if (r < 50) return 5;
        return $urandom_range(5);
    endfunction

    function automatic logic [STATUS_W-1:0] status_in_class(input int cls);
        if (cls == 0) begin
            return ($urandom_range(1) == 0) ? STATUS_W'($urandom_range(99))
                                            : STATUS_W'($urandom_range(1023, 600));
        end
        return STATUS_W'(cls * 100 + $urandom_range(99));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_duration();
        int pick;
        int k;
        logic [VALUE_W-1:0] low;
        logic [VALUE_W-1:0] high;
        pick = $urandom_range(99);
        if (pick < 10) return {$urandom, $urandom};
        if (pick < 20) begin
            k = $urandom_range(BUCKET_COUNT - 1);
            return limit_ns[k] + 64'($urandom_range(2)) - 64'd1;
        end
        if (pick < 23) return '0;
        if (pick < 26) return MAX_NS;
        if (pick < 31) return {$urandom | 32'h8000_0000, $urandom};
        k = $urandom_range(BUCKET_COUNT);
        low  = (k == 0) ? 64'd0 : limit_ns[k-1] + 64'd1;
        high = (k == BUCKET_COUNT) ? limit_ns[BUCKET_COUNT-1] * 4 : limit_ns[k];
        return low + ({$urandom, $urandom} % (high - low + 64'd1));
    endfunction

    task automatic offer_random_request();
        int pick;
        int r;
        logic [CMD_W-1:0]    cmd;
        logic [METHOD_W-1:0] method;
        logic [STATUS_W-1:0] status;
        logic [CLASS_W-1:0]  qclass;
        logic [SLOT_W-1:0]   last_bucket;
        pick = $urandom_range(999);
        if (pick < 450)      cmd = CMD_RECORD;
        else if (pick < 610) cmd = CMD_READ_BUCKET;
        else if (pick < 720) cmd = CMD_READ_COUNT;
        else if (pick < 810) cmd = CMD_READ_SUM;
        else if (pick < 890) cmd = CMD_READ_ERRORS;
        else if (pick < 900) cmd = CMD_CLEAR;
        else if (pick < 940) cmd = ($urandom_range(1) == 0) ? CMD_SPARE_LOW : CMD_SPARE_HIGH;
        else                 cmd = CMD_RECORD;
        r = $urandom_range(99);
        if (r < 50)      method = METHOD_W'($urandom_range(2));
        else if (r < 85) method = METHOD_W'($urandom_range(9));
        else             method = METHOD_W'($urandom_range(15));
        status = ($urandom_range(99) < 90) ? status_in_class(pick_class())
                                           : STATUS_W'($urandom_range(1023));
        qclass = ($urandom_range(99) < 88) ? CLASS_W'(pick_class())
                                           : CLASS_W'($urandom_range(7));
        last_bucket = ($urandom_range(99) < 88) ? SLOT_W'($urandom_range(10))
                                                : SLOT_W'($urandom_range(15));
        offer_request(cmd, method, status, qclass, last_bucket, pick_duration());
    endtask

    initial begin : stimulus
        int phase;
        limit_ns[0]  = 64'd5000000;
        limit_ns[1]  = 64'd10000000;
        limit_ns[2]  = 64'd25000000;
        limit_ns[3]  = 64'd50000000;
        limit_ns[4]  = 64'd100000000;
        limit_ns[5]  = 64'd250000000;
        limit_ns[6]  = 64'd500000000;
        limit_ns[7]  = 64'd1000000000;
        limit_ns[8]  = 64'd2500000000;
        limit_ns[9]  = 64'd5000000000;
        limit_ns[10] = 64'd10000000000;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        set_metrics(1'b1);

        // bucket edges, class edges, method clamp, sum wrap, rejects, spare codes
        offer_request(CMD_READ_ERRORS, 4'd0, 10'd0, 3'd0, 4'd0, 64'd0);
        offer_request(CMD_RECORD, 4'd0, 10'd200, 3'd0, 4'd0, 64'd0);
        offer_request(CMD_RECORD, 4'd9, 10'd599, 3'd0, 4'd0, 64'd5000000);
        offer_request(CMD_RECORD, 4'd9, 10'd600, 3'd0, 4'd0, 64'd5000001);
        offer_request(CMD_RECORD, 4'd15, 10'd99, 3'd0, 4'd0, MAX_NS);
        offer_request(CMD_RECORD, 4'd10, 10'd100, 3'd0, 4'd0, 64'd10000000000);
        offer_request(CMD_RECORD, 4'd3, 10'd1023, 3'd0, 4'd0, 64'd10000000001);
        offer_request(CMD_RECORD, 4'd0, 10'd0, 3'd0, 4'd0, MAX_NS);
        offer_request(CMD_READ_BUCKET, 4'd0, 10'd0, 3'd0, 4'd10, 64'd0);
        offer_request(CMD_READ_BUCKET, 4'd0, 10'd0, 3'd0, 4'd0, 64'd0);
        offer_request(CMD_READ_BUCKET, 4'd0, 10'd0, 3'd6, 4'd0, 64'd0);
        offer_request(CMD_READ_BUCKET, 4'd0, 10'd0, 3'd0, 4'd11, 64'd0);
        offer_request(CMD_READ_BUCKET, 4'd15, 10'd1023, 3'd7, 4'd15, MAX_NS);
        offer_request(CMD_READ_COUNT, 4'd0, 10'd0, 3'd0, 4'd0, 64'd0);
        offer_request(CMD_READ_SUM, 4'd0, 10'd0, 3'd0, 4'd0, 64'd0);
        offer_request(CMD_READ_COUNT, 4'd0, 10'd0, 3'd7, 4'd0, 64'd0);
        offer_request(CMD_READ_SUM, 4'd0, 10'd0, 3'd6, 4'd0, 64'd0);
        offer_request(CMD_READ_ERRORS, 4'd9, 10'd0, 3'd0, 4'd0, 64'd0);
        offer_request(CMD_READ_ERRORS, 4'd15, 10'd1023, 3'd7, 4'd15, MAX_NS);
        offer_request(CMD_SPARE_LOW, 4'd1, 10'd500, 3'd1, 4'd1, 64'd1);
        offer_request(CMD_SPARE_HIGH, 4'd15, 10'd1023, 3'd7, 4'd15, MAX_NS);
        offer_request(CMD_CLEAR, 4'd0, 10'd0, 3'd0, 4'd0, 64'd0);
        offer_request(CMD_READ_COUNT, 4'd0, 10'd0, 3'd0, 4'd0, 64'd0);
        offer_request(CMD_READ_ERRORS, 4'd9, 10'd0, 3'd0, 4'd0, 64'd0);
        offer_request(CMD_RECORD, 4'd1, 10'd250, 3'd0, 4'd0, 64'd12345678);
        await_drain();

        // record while disabled changes nothing, clear still acts
        set_metrics(1'b0);
        offer_request(CMD_RECORD, 4'd1, 10'd250, 3'd0, 4'd0, 64'd7);
        offer_request(CMD_READ_COUNT, 4'd1, 10'd0, 3'd2, 4'd0, 64'd0);
        offer_request(CMD_CLEAR, 4'd0, 10'd0, 3'd0, 4'd0, 64'd0);
        offer_request(CMD_READ_COUNT, 4'd1, 10'd0, 3'd2, 4'd0, 64'd0);
        await_drain();

        for (phase = 0; phase < PHASES; phase++) begin
            set_metrics((phase == 2 || phase == 5) ? 1'b0 : 1'b1);
            steady     = (phase == 1);
            hold_phase = (phase == 3);
            repeat (ITEMS_PER_PHASE) offer_random_request();
            await_drain();
        end
        steady     = 1'b0;
        hold_phase = 1'b0;

        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
